[hdl/lsim_pkg.sv]
package lsim_pkg;

   // default word capacity in bytes
   localparam int MAX_LEN_DEF = 32;

   // fixed field widths of the transactions
   localparam int TYPE_W = 2;
   localparam int CHAR_W = 8;
   localparam int DIST_W = 6;
   localparam int LEN_W  = 6;
   localparam int SIM_W  = 16;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_FIRST   = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_SECOND  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_COMPARE = 2'd2;

   // q1.15 quotient: one integer bit plus fifteen fraction bits
   localparam int QUO_W = 16;
   localparam int QCNT_W = $clog2(QUO_W);
   localparam logic [QCNT_W-1:0] QCNT_LAST = QCNT_W'(QUO_W - 1);
   localparam logic [SIM_W:0] SIM_ONE = 17'd32768;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_first;
      logic load_second;
      logic start;
      logic init_wr;
      logic row_start;
      logic cell_read;
      logic cell_calc;
      logic div_start;
      logic div_step;
      logic finish;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic empty;
      logic trivial;
      logic init_last;
      logic j_last;
      logic i_last;
      logic div_last;
      logic out_free;
   } stat_type;

endpackage

[hdl/lsim_ram.sv]
module lsim_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/lsim_ctrl.sv]
module lsim_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic [lsim_pkg::TYPE_W-1:0]       req_type,
   output logic                              req_ready,
   input  lsim_pkg::stat_type                stat,
   output lsim_pkg::cmd_type                 cmd
);
   import lsim_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_INIT      = 3'd1;
   localparam logic [2:0] ST_ROW       = 3'd2;
   localparam logic [2:0] ST_CELL_READ = 3'd3;
   localparam logic [2:0] ST_CELL_CALC = 3'd4;
   localparam logic [2:0] ST_DIV_INIT  = 3'd5;
   localparam logic [2:0] ST_DIV_STEP  = 3'd6;
   localparam logic [2:0] ST_FINISH    = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_type)
                  REQ_FIRST:  cmd.load_first = 1'b1;
                  REQ_SECOND: cmd.load_second = 1'b1;
                  REQ_COMPARE: begin
                     cmd.start = 1'b1;
                     priority if (stat.empty) begin
                        state_in = ST_FINISH;
                     end else if (stat.trivial) begin
                        state_in = ST_DIV_INIT;
                     end else begin
                        state_in = ST_INIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (stat.init_last) begin
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            cmd.row_start = 1'b1;
            state_in = ST_CELL_READ;
         end
         ST_CELL_READ: begin
            cmd.cell_read = 1'b1;
            state_in = ST_CELL_CALC;
         end
         ST_CELL_CALC: begin
            cmd.cell_calc = 1'b1;
            priority if (stat.j_last && stat.i_last) begin
               state_in = ST_DIV_INIT;
            end else if (stat.j_last) begin
               state_in = ST_ROW;
            end else begin
               state_in = ST_CELL_READ;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // at most one command per cycle
   assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("more than one datapath command");

   // result published only when the output register can take it
   assert property (@(posedge clock) disable iff (reset) cmd.finish |-> stat.out_free)
      else $error("result overwrites a pending transaction");

endmodule

[hdl/lsim_dp.sv]
module lsim_dp #(
   parameter int MAX_LEN = lsim_pkg::MAX_LEN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lsim_pkg::cmd_type                 cmd,
   output lsim_pkg::stat_type                stat,
   input  logic [lsim_pkg::CHAR_W-1:0]       req_char_code,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lsim_pkg::DIST_W-1:0]       rsp_distance,
   output logic [lsim_pkg::LEN_W-1:0]        rsp_longer_length,
   output logic [lsim_pkg::SIM_W-1:0]        rsp_similarity,
   output logic                              rsp_both_empty,
   output logic                              rsp_truncated
);
   import lsim_pkg::*;

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam logic [LW-1:0] FULL = LW'(MAX_LEN);

   logic [LW-1:0]     len1_ff, len2_ff;
   logic              ovf_ff;
   logic [LW-1:0]     i_ff, j_ff;
   logic [LW-1:0]     left_ff, diag_ff, dist_ff;
   logic [LW:0]       rem_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [QCNT_W-1:0] qcnt_ff;
   logic              rsp_valid_ff;
   logic [DIST_W-1:0] rsp_distance_ff;
   logic [LEN_W-1:0]  rsp_longer_ff;
   logic [SIM_W-1:0]  rsp_similarity_ff;
   logic              rsp_both_empty_ff;
   logic              rsp_truncated_ff;

   logic [LW-1:0]     longer;
   logic              room1, room2;
   logic [CHAR_W-1:0] first_rd, second_rd;
   logic [LW-1:0]     cost_rd;
   logic              cost_we;
   logic [LW-1:0]     cost_wr_addr, cost_wr_data;
   logic [LW-1:0]     min_ab, min_abc, cell_val;
   logic              div_ge;
   logic [LW:0]       rem_sub;
   logic [SIM_W:0]    sim_full;

   assign longer = (len1_ff > len2_ff) ? len1_ff : len2_ff;
   assign room1  = len1_ff < FULL;
   assign room2  = len2_ff < FULL;

   // word stores, written at the current length
   lsim_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN), .AW(AW)) u_first (
      .clock   (clock),
      .wr_en   (cmd.load_first && room1),
      .wr_addr (len1_ff[AW-1:0]),
      .wr_data (req_char_code),
      .rd_en   (cmd.row_start),
      .rd_addr (AW'(i_ff - 1'b1)),
      .rd_data (first_rd)
   );

   lsim_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN), .AW(AW)) u_second (
      .clock   (clock),
      .wr_en   (cmd.load_second && room2),
      .wr_addr (len2_ff[AW-1:0]),
      .wr_data (req_char_code),
      .rd_en   (cmd.cell_read),
      .rd_addr (AW'(j_ff - 1'b1)),
      .rd_data (second_rd)
   );

   // single row of cost cells
   lsim_ram #(.WIDTH(LW), .DEPTH(MAX_LEN + 1), .AW(LW)) u_cost (
      .clock   (clock),
      .wr_en   (cost_we),
      .wr_addr (cost_wr_addr),
      .wr_data (cost_wr_data),
      .rd_en   (cmd.cell_read),
      .rd_addr (j_ff),
      .rd_data (cost_rd)
   );

   // cell update: match takes diagonal, else one plus the smallest neighbor
   always_comb begin
      min_ab   = (cost_rd < left_ff) ? cost_rd : left_ff;
      min_abc  = (min_ab < diag_ff) ? min_ab : diag_ff;
      cell_val = (first_rd == second_rd) ? diag_ff : LW'({1'b0, min_abc} + 1'b1);
   end

   // cost row write port
   always_comb begin
      cost_we = cmd.init_wr || cmd.row_start || cmd.cell_calc;
      if (cmd.row_start) begin
         cost_wr_addr = '0;
         cost_wr_data = i_ff;
      end else if (cmd.cell_calc) begin
         cost_wr_addr = j_ff;
         cost_wr_data = cell_val;
      end else begin
         cost_wr_addr = j_ff;
         cost_wr_data = j_ff;
      end
   end

   // restoring division step, one quotient bit per cycle
   always_comb begin
      div_ge  = rem_ff >= {1'b0, longer};
      rem_sub = div_ge ? (rem_ff - {1'b0, longer}) : rem_ff;
      sim_full = SIM_ONE - {1'b0, quo_ff};
   end

   // status
   always_comb begin
      stat.empty     = longer == '0;
      stat.trivial   = (len1_ff == '0) || (len2_ff == '0);
      stat.init_last = j_ff == len2_ff;
      stat.j_last    = j_ff == len2_ff;
      stat.i_last    = i_ff == len1_ff;
      stat.div_last  = qcnt_ff == QCNT_LAST;
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // word lengths and overflow flag
   always_ff @(posedge clock) begin
      if (reset) begin
         len1_ff <= '0;
         len2_ff <= '0;
         ovf_ff  <= 1'b0;
      end else if (cmd.finish) begin
         len1_ff <= '0;
         len2_ff <= '0;
         ovf_ff  <= 1'b0;
      end else if (cmd.load_first) begin
         if (room1) begin
            len1_ff <= len1_ff + 1'b1;
         end else begin
            ovf_ff <= 1'b1;
         end
      end else if (cmd.load_second) begin
         if (room2) begin
            len2_ff <= len2_ff + 1'b1;
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   // sweep counters, neighbor cells and divider
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         dist_ff <= longer;
         i_ff    <= LW'(1);
         j_ff    <= '0;
      end
      if (cmd.init_wr) begin
         j_ff <= j_ff + 1'b1;
      end
      if (cmd.row_start) begin
         left_ff <= i_ff;
         diag_ff <= i_ff - 1'b1;
         j_ff    <= LW'(1);
      end
      if (cmd.cell_calc) begin
         left_ff <= cell_val;
         diag_ff <= cost_rd;
         dist_ff <= cell_val;
         j_ff    <= j_ff + 1'b1;
         if (stat.j_last) begin
            i_ff <= i_ff + 1'b1;
         end
      end
      if (cmd.div_start) begin
         rem_ff  <= {1'b0, dist_ff};
         quo_ff  <= '0;
         qcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= {rem_sub[LW-1:0], 1'b0};
         quo_ff  <= {quo_ff[QUO_W-2:0], div_ge};
         qcnt_ff <= qcnt_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_both_empty_ff <= stat.empty;
         rsp_truncated_ff  <= ovf_ff;
         rsp_longer_ff     <= LEN_W'(longer);
         if (stat.empty) begin
            rsp_distance_ff   <= '0;
            rsp_similarity_ff <= '0;
         end else begin
            rsp_distance_ff   <= DIST_W'(dist_ff);
            rsp_similarity_ff <= sim_full[SIM_W-1:0];
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_distance      = rsp_distance_ff;
   assign rsp_longer_length = rsp_longer_ff;
   assign rsp_similarity    = rsp_similarity_ff;
   assign rsp_both_empty    = rsp_both_empty_ff;
   assign rsp_truncated     = rsp_truncated_ff;

   // lengths never pass the word capacity
   assert property (@(posedge clock) disable iff (reset)
      (len1_ff <= FULL) && (len2_ff <= FULL))
      else $error("word length beyond capacity");

   // a compare leaves both words empty
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (len1_ff == '0) && (len2_ff == '0) && !ovf_ff)
      else $error("words not cleared after compare");

endmodule

[hdl/levenshtein_similarity_core.sv]
// levenshtein similarity core
// input channel req_*: req_type 0 appends req_char_code to the first word, 1 to
// the second word, 2 compares the two words and clears them; type 3 is ignored.
// bytes past MAX_LEN are dropped and reported in rsp_truncated of the next compare.
// result channel rsp_*: one transaction per compare with edit distance, longer
// length, q1.15 similarity (32768 = identical) and a both-empty flag.
// a load is taken in the idle state, which the controller keeps. a compare runs
// through an accept step, seeding of the cost row, then for each row a setup
// step and per cell a read step and a calculate step (registered reads of
// the word and cost memories), then bit-serial division and a publish step;
// a one-sided compare skips seeding and sweep, an empty one also the division.
// reset is synchronous: words empty, overflow flag clear, no pending result.
// the result sits in an output register; while rsp_ready is low further loads
// are taken, and a following compare finishes its sweep and then waits.
module levenshtein_similarity_core #(
   parameter int MAX_LEN = lsim_pkg::MAX_LEN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lsim_pkg::TYPE_W-1:0]       req_type,
   input  logic [lsim_pkg::CHAR_W-1:0]       req_char_code,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lsim_pkg::DIST_W-1:0]       rsp_distance,
   output logic [lsim_pkg::LEN_W-1:0]        rsp_longer_length,
   output logic [lsim_pkg::SIM_W-1:0]        rsp_similarity,
   output logic                              rsp_both_empty,
   output logic                              rsp_truncated
);
   import lsim_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer for loads, cost sweep and division
   lsim_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // word stores, cost row, divider and result register
   lsim_dp #(.MAX_LEN(MAX_LEN)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_distance      (rsp_distance),
      .rsp_longer_length (rsp_longer_length),
      .rsp_similarity    (rsp_similarity),
      .rsp_both_empty    (rsp_both_empty),
      .rsp_truncated     (rsp_truncated)
   );

endmodule

[dv/levenshtein_similarity_core_tb.sv]
module levenshtein_similarity_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lsim_pkg::*;

   localparam int WORD_CAP = MAX_LEN_DEF;
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 450;
   localparam int HOLD_CYCLES = 3000;

   // one result transaction
   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [LEN_W-1:0]  longer_length;
      logic [SIM_W-1:0]  similarity;
      logic              both_empty;
      logic              truncated;
   } score_type;

   // word store, edit distance predictor and expected result queue
   class similarity_scoreboard_type;
      logic [CHAR_W-1:0] first_word[WORD_CAP];
      logic [CHAR_W-1:0] second_word[WORD_CAP];
      int first_len;
      int second_len;
      bit overflow_seen;
      score_type expected_q[$];
      int fail_count;

      // two-row dynamic program, unit costs
      function int edit_distance();
         int prev_row[WORD_CAP+1];
         int cur_row[WORD_CAP+1];
         int sub_cost;
         int best;
         for (int j = 0; j <= second_len; j++)
            prev_row[j] = j;
         for (int i = 1; i <= first_len; i++) begin
            cur_row[0] = i;
            for (int j = 1; j <= second_len; j++) begin
               sub_cost = prev_row[j-1] + ((first_word[i-1] != second_word[j-1]) ? 1 : 0);
               best = prev_row[j] + 1;
               if (cur_row[j-1] + 1 < best)
                  best = cur_row[j-1] + 1;
               if (sub_cost < best)
                  best = sub_cost;
               cur_row[j] = best;
            end
            prev_row = cur_row;
         end
         return prev_row[second_len];
      endfunction

      // update the words for an accepted input transaction; a compare queues the expected result
      function void note_request(input logic [TYPE_W-1:0] kind, input logic [CHAR_W-1:0] code);
         score_type want;
         int longer;
         int edit_cost;
         int sim;
         case (kind)
            REQ_FIRST: begin
               if (first_len < WORD_CAP) begin
                  first_word[first_len] = code;
                  first_len++;
               end else begin
                  overflow_seen = 1'b1;
               end
            end
            REQ_SECOND: begin
               if (second_len < WORD_CAP) begin
                  second_word[second_len] = code;
                  second_len++;
               end else begin
                  overflow_seen = 1'b1;
               end
            end
            REQ_COMPARE: begin
               longer = (first_len > second_len) ? first_len : second_len;
               if (longer == 0) begin
                  edit_cost = 0;
                  sim = 0;
               end else begin
                  edit_cost = edit_distance();
                  sim = 32768 - (edit_cost * 32768) / longer;
               end
               want.distance      = DIST_W'(edit_cost);
               want.longer_length = LEN_W'(longer);
               want.similarity    = SIM_W'(sim);
               want.both_empty    = (longer == 0);
               want.truncated     = overflow_seen;
               expected_q.insert(expected_q.size(), want);
               first_len = 0;
               second_len = 0;
               overflow_seen = 1'b0;
            end
            default: ;
         endcase
      endfunction

      task report(input string msg);
         $display("%0t ns mismatch: %s", $time, msg);
         fail_count++;
      endtask

      // compare a result transaction with the oldest expectation
      task check_result(input score_type got);
         score_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result with no compare pending (distance %0d)", got.distance));
            return;
         end
         want = expected_q.pop_front();
         if (got.distance != want.distance)
            report($sformatf("distance %0d, want %0d", got.distance, want.distance));
         if (got.longer_length != want.longer_length)
            report($sformatf("longer_length %0d, want %0d", got.longer_length,
                             want.longer_length));
         if (got.similarity != want.similarity)
            report($sformatf("similarity %0d, want %0d", got.similarity, want.similarity));
         if (got.both_empty != want.both_empty)
            report($sformatf("both_empty %0b, want %0b", got.both_empty, want.both_empty));
         if (got.truncated != want.truncated)
            report($sformatf("truncated %0b, want %0b", got.truncated, want.truncated));
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [TYPE_W-1:0]   req_type;
   logic [CHAR_W-1:0]   req_char_code;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [DIST_W-1:0]   rsp_distance;
   logic [LEN_W-1:0]    rsp_longer_length;
   logic [SIM_W-1:0]    rsp_similarity;
   logic                rsp_both_empty;
   logic                rsp_truncated;

   logic calm;
   logic random_phase;
   logic hold_rsp;
   int   items_sent;

   similarity_scoreboard_type scores = new;

   levenshtein_similarity_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_distance      (rsp_distance),
      .rsp_longer_length (rsp_longer_length),
      .rsp_similarity    (rsp_similarity),
      .rsp_both_empty    (rsp_both_empty),
      .rsp_truncated     (rsp_truncated)
   );

   always #10 clock = ~clock;

   // offer one input transaction, with random idle cycles ahead of it
   task automatic send_item(input logic [TYPE_W-1:0] kind, input logic [CHAR_W-1:0] code);
      while (!calm && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_char_code <= code;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      scores.note_request(kind, code);
      if (kind != REQ_UNUSED)
         items_sent++;
   endtask

   // load two words in random interleaving, then usually compare
   task automatic send_word_pair();
      logic [CHAR_W-1:0] word_a[WORD_CAP+4];
      logic [CHAR_W-1:0] word_b[WORD_CAP+4];
      int len_a;
      int len_b;
      int ia;
      int ib;
      bit wide;
      wide = ($urandom_range(0, 3) == 0);
      len_a = ($urandom_range(0, 99) < 6) ? $urandom_range(WORD_CAP - 2, WORD_CAP + 3)
                                          : $urandom_range(0, 8);
      for (int k = 0; k < len_a; k++)
         word_a[k] = wide ? CHAR_W'($urandom) : CHAR_W'(8'h61 + $urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) begin
         // near copy of the first word
         len_b = len_a;
         word_b = word_a;
         if (len_b > 0 && $urandom_range(0, 1) == 1)
            word_b[$urandom_range(0, len_b - 1)] = CHAR_W'($urandom);
      end else begin
         len_b = ($urandom_range(0, 99) < 6) ? $urandom_range(WORD_CAP - 2, WORD_CAP + 3)
                                             : $urandom_range(0, 8);
         for (int k = 0; k < len_b; k++)
            word_b[k] = wide ? CHAR_W'($urandom) : CHAR_W'(8'h61 + $urandom_range(0, 3));
      end
      ia = 0;
      ib = 0;
      while (ia < len_a || ib < len_b) begin
         if ($urandom_range(0, 99) < 4) begin
            send_item(REQ_UNUSED, CHAR_W'($urandom));
         end else if (ib >= len_b || (ia < len_a && $urandom_range(0, 1) == 1)) begin
            send_item(REQ_FIRST, word_a[ia]);
            ia++;
         end else begin
            send_item(REQ_SECOND, word_b[ib]);
            ib++;
         end
      end
      // a few sequences run on into the next one without a compare
      if ($urandom_range(0, 99) >= 5)
         send_item(REQ_COMPARE, CHAR_W'($urandom));
   endtask

   // stimulus and end of run
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_type      = REQ_FIRST;
      req_char_code = '0;
      calm          = 1'b0;
      random_phase  = 1'b0;
      items_sent    = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // both words empty, ignored request type
      send_item(REQ_COMPARE, 8'h00);
      send_item(REQ_UNUSED, 8'hff);
      // identical words with extreme bytes
      send_item(REQ_FIRST, 8'h00);
      send_item(REQ_FIRST, 8'hff);
      send_item(REQ_SECOND, 8'h00);
      send_item(REQ_SECOND, 8'hff);
      send_item(REQ_COMPARE, 8'hff);
      // only the first word loaded
      send_item(REQ_FIRST, 8'haa);
      send_item(REQ_COMPARE, 8'h00);
      // only the second word loaded
      send_item(REQ_SECOND, 8'h55);
      send_item(REQ_SECOND, 8'h12);
      send_item(REQ_COMPARE, 8'h00);
      // one substitution with an ignored request in between
      send_item(REQ_FIRST, 8'h6b);
      send_item(REQ_FIRST, 8'h69);
      send_item(REQ_SECOND, 8'h73);
      send_item(REQ_UNUSED, 8'h00);
      send_item(REQ_FIRST, 8'h74);
      send_item(REQ_SECOND, 8'h69);
      send_item(REQ_SECOND, 8'h74);
      send_item(REQ_COMPARE, 8'h00);

      // random word pairs, with a stretch free of idle cycles
      random_phase <= 1'b1;
      while (items_sent < ITEM_TARGET) begin
         calm <= (items_sent >= 200 && items_sent < 300);
         send_word_pair();
      end
      req_valid <= 1'b0;
      calm <= 1'b0;

      // drain outstanding results
      while (scores.pending() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (scores.fail_count == 0)
         $display("levenshtein_similarity_core_tb OK");
      else
         $display("levenshtein_similarity_core_tb NOT OK");
      $finish;
   end

   // result receiver with random stalls
   initial begin
      score_type got;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.distance      = rsp_distance;
            got.longer_length = rsp_longer_length;
            got.similarity    = rsp_similarity;
            got.both_empty    = rsp_both_empty;
            got.truncated     = rsp_truncated;
            scores.check_result(got);
         end
         rsp_ready <= !hold_rsp && (calm || $urandom_range(0, 99) >= 17);
      end
   end

   // long receiver hold-off so the block backs up and stalls its input
   initial begin
      hold_rsp = 1'b0;
      wait (random_phase);
      repeat ($urandom_range(100, 600)) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("levenshtein_similarity_core_tb NOT OK");
      $finish;
   end

endmodule

[files.f]
hdl/lsim_pkg.sv
hdl/lsim_ram.sv
hdl/lsim_ctrl.sv
hdl/lsim_dp.sv
hdl/levenshtein_similarity_core.sv
dv/levenshtein_similarity_core_tb.sv
